FILE: sv/oops_pkg.sv
// ----------------------------------------------------------------------------
// oops_pkg: shared types and constants of the offset pursuit steering block
// Holds the register map, the CORDIC arctangent table, the controller state
// and datapath operation codes, and the structs that join the two.
// ----------------------------------------------------------------------------
package oops_pkg;

    // Number of CORDIC micro-rotations (legal range 8 to 24).
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int IDX_W        = $clog2(ATAN_LEN);
    // The square root of a 32-bit radicand settles one result bit per step.
    localparam int ISQRT_STEPS  = 16;
    localparam int ITER_STEPS   = (CORDIC_STEPS > ISQRT_STEPS) ? CORDIC_STEPS : ISQRT_STEPS;

    // Widths of the CORDIC vector and angle registers.
    localparam int CW = 20;
    localparam int ZW = 20;
    // Shared multiplier operand and product widths.
    localparam int MW = 17;
    localparam int PW = 2 * MW;

    // Quarter turn in radians scaled by 65536.
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(102944);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAFE_DISTANCE    = 3'd0,
        REG_RELEASE_MARGIN   = 3'd1,
        REG_AVOIDANCE_OFFSET = 3'd2,
        REG_FORWARD_BIAS     = 3'd3,
        REG_MAX_LINEAR_SPEED = 3'd4,
        REG_LINEAR_GAIN      = 3'd5,
        REG_MAX_ANGULAR_RATE = 3'd6,
        REG_ANGULAR_GAIN     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [14:0]        safe_distance;
        logic [14:0]        release_margin;
        logic [14:0]        avoidance_offset;
        logic signed [15:0] forward_bias;
        logic [15:0]        max_linear_speed;
        logic [9:0]         linear_gain;
        logic [14:0]        max_angular_rate;
        logic [9:0]         angular_gain;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQY,
        S_SQZ,
        S_SQIN,
        S_SQOUT,
        S_GOALY,
        S_SQGX,
        S_SQGY,
        S_INIT,
        S_ITER,
        S_SPEED,
        S_RATE,
        S_CLAMP,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQY,
        OP_SQZ,
        OP_SQIN,
        OP_SQOUT,
        OP_GOALY,
        OP_SQGX,
        OP_SQGY,
        OP_INIT,
        OP_ITER,
        OP_SPEED,
        OP_RATE,
        OP_CLAMP,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic first;
    } t_cmd;

    typedef struct packed {
        logic iter_done;
        logic last;
    } t_status;

    // atan(2^-i) in radians scaled by 65536.
    function automatic logic [16:0] atan_q16(input logic [IDX_W-1:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30385;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/obstacle_offset_pursuit_steering.sv
// ----------------------------------------------------------------------------
// obstacle_offset_pursuit_steering: goal point and drive command generator
// Turns obstacle centroids into offset goal points and, once per frame, a
// linear speed and turn rate toward the goal.
// ----------------------------------------------------------------------------
// Each accepted centroid beat yields exactly one result beat. The block works
// on one centroid at a time: a centroid that is not the first of its frame
// passes through four uses of the shared 17 by 17 multiplier (y squared, z
// squared, and the inner and outer radius squared) and the goal compare before
// its output register is loaded. The first centroid of a frame also runs the
// square root and CORDIC loop, which run side by side for max(16, CORDIC_STEPS)
// steps. After loading the output register the block returns to idle, and only
// there accepts the next centroid, so it never takes a new centroid before it
// is through with the last; a result still waiting on a stalled output holds
// it in its done state. The
// output register lets the next centroid be taken while a result waits. After
// reset the next centroid starts a frame; a beat with s_axis_tlast high makes
// the following one start a new frame. Configuration is written through a
// plain write port and should only change while no beat is in flight.
// ----------------------------------------------------------------------------
module obstacle_offset_pursuit_steering import oops_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Centroid input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, from bit 0: centroid_x[15:0], centroid_y[31:16], centroid_z[47:32]
    input  logic [47:0]           s_axis_tdata,
    // tlast: frame_end
    input  logic                  s_axis_tlast,
    // Goal output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, from bit 0: goal_x[15:0], goal_y[31:16], linear_speed[47:32],
    // angular_rate[63:48]
    output logic [63:0]           m_axis_tdata,
    // tuser: command_valid
    output logic                  m_axis_tuser,
    // tlast: frame_last
    output logic                  m_axis_tlast
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    // Register file. Every index of the three-bit address maps to a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.safe_distance    <= 15'd512;
            r_cfg.release_margin   <= 15'd256;
            r_cfg.avoidance_offset <= 15'd256;
            r_cfg.forward_bias     <= 16'sd26;
            r_cfg.max_linear_speed <= 16'd128;
            r_cfg.linear_gain      <= 10'd128;
            r_cfg.max_angular_rate <= 15'd8192;
            r_cfg.angular_gain     <= 10'd256;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SAFE_DISTANCE:    r_cfg.safe_distance    <= i_cfg_data[14:0];
                REG_RELEASE_MARGIN:   r_cfg.release_margin   <= i_cfg_data[14:0];
                REG_AVOIDANCE_OFFSET: r_cfg.avoidance_offset <= i_cfg_data[14:0];
                REG_FORWARD_BIAS:     r_cfg.forward_bias     <= signed'(i_cfg_data);
                REG_MAX_LINEAR_SPEED: r_cfg.max_linear_speed <= i_cfg_data;
                REG_LINEAR_GAIN:      r_cfg.linear_gain      <= i_cfg_data[9:0];
                REG_MAX_ANGULAR_RATE: r_cfg.max_angular_rate <= i_cfg_data[14:0];
                REG_ANGULAR_GAIN:     r_cfg.angular_gain     <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // The controller sequences the work; the datapath holds all arithmetic.
    oops_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    oops_dp u_dp (
        .i_clk     (i_clk),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .i_s_tdata (s_axis_tdata),
        .i_s_tlast (s_axis_tlast),
        .o_status  (status),
        .o_m_tdata (m_axis_tdata),
        .o_m_tuser (m_axis_tuser),
        .o_m_tlast (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // Only one centroid is in flight, so acceptance never repeats back to back.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second beat accepted while busy");

    // A result without a drive command carries zero speed and rate.
    a_no_command_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[63:32] == 32'd0))
        else $error("speed or rate set on a beat without a command");

    // While a result that ends a frame waits, the next centroid starts a frame.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> cmd.first)
        else $error("frame start not tracked");
`endif

endmodule

FILE: sv/oops_ctrl.sv
// ----------------------------------------------------------------------------
// oops_ctrl: sequencing controller
// Walks each centroid through the goal steps, the first of a frame also through
// the drive command steps; tracks frame starts and owns o_m_tvalid.
// ----------------------------------------------------------------------------
module oops_ctrl import oops_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_m_tready,
    output logic    o_m_tvalid,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_first;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
                r_first     <= i_status.last;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_cmd.first = r_first;
        o_s_tready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_SQY;
                end
            end
            S_SQY: begin
                o_cmd.op = OP_SQY;
                n_state  = S_SQZ;
            end
            S_SQZ: begin
                o_cmd.op = OP_SQZ;
                n_state  = S_SQIN;
            end
            S_SQIN: begin
                o_cmd.op = OP_SQIN;
                n_state  = S_SQOUT;
            end
            S_SQOUT: begin
                o_cmd.op = OP_SQOUT;
                n_state  = S_GOALY;
            end
            S_GOALY: begin
                o_cmd.op = OP_GOALY;
                n_state  = r_first ? S_SQGX : S_DONE;
            end
            S_SQGX: begin
                o_cmd.op = OP_SQGX;
                n_state  = S_SQGY;
            end
            S_SQGY: begin
                o_cmd.op = OP_SQGY;
                n_state  = S_INIT;
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = S_ITER;
            end
            S_ITER: begin
                o_cmd.op = OP_ITER;
                if (i_status.iter_done) begin
                    n_state = S_SPEED;
                end
            end
            S_SPEED: begin
                o_cmd.op = OP_SPEED;
                n_state  = S_RATE;
            end
            S_RATE: begin
                o_cmd.op = OP_RATE;
                n_state  = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted centroid always starts the squaring sequence.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_SQY))
        else $error("accepted beat did not start the sequence");

    // The iteration loop holds until the datapath reports its last step.
    a_iter_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER && !i_status.iter_done) |=> (r_state == S_ITER))
        else $error("iteration loop left early");

    // Only the first centroid of a frame runs the drive command steps.
    a_skip_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GOALY && !r_first) |=> (r_state == S_DONE))
        else $error("drive command computed for a later centroid");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> out_free)
        else $error("output register loaded while full");
`endif

endmodule

FILE: sv/oops_dp.sv
// ----------------------------------------------------------------------------
// oops_dp: goal and drive command datapath
// One shared multiplier with a registered product, an iterative square root
// and an iterative CORDIC arctangent, plus the output register.
// ----------------------------------------------------------------------------
module oops_dp import oops_pkg::*; (
    input  logic        i_clk,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic [47:0] i_s_tdata,
    input  logic        i_s_tlast,
    output t_status     o_status,
    output logic [63:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    // Captured item.
    logic signed [15:0] r_gx;
    logic signed [15:0] r_cy;
    logic signed [15:0] r_cz;
    logic               r_last;
    logic signed [15:0] r_gy;

    // Shared multiplier.
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] r_prod;

    // Distance tests.
    logic [31:0] r_d2;
    logic        r_lt;
    logic [31:0] r_rad;

    // Square root.
    logic [31:0] r_rem;
    logic [31:0] r_root;
    logic [31:0] r_bit;
    logic [32:0] trial;

    // CORDIC.
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_zero;
    logic [IDX_W-1:0]     r_cnt;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] atan_s;
    logic signed [ZW-1:0] z_rnd;

    // Drive command.
    logic signed [15:0] r_ang;
    logic [15:0]        r_speed;
    logic signed [15:0] r_rate;

    // Combinational helpers.
    logic signed [16:0] sum_x;
    logic signed [15:0] gx_sat;
    logic signed [15:0] side;
    logic [15:0]        outer_r;
    logic [17:0]        speed_raw;
    logic signed [25:0] rate_raw;
    logic signed [25:0] lim;
    logic signed [25:0] rate_clamp;
    logic signed [CW-1:0] gx_ext;
    logic signed [CW-1:0] gy_ext;

    // Output register.
    logic signed [15:0] r_o_goal_x;
    logic signed [15:0] r_o_goal_y;
    logic [15:0]        r_o_speed;
    logic signed [15:0] r_o_rate;
    logic               r_o_valid;
    logic               r_o_last;

    assign sum_x  = 17'(signed'(i_s_tdata[15:0])) + 17'(i_cfg.forward_bias);
    assign gx_sat = (sum_x[16] != sum_x[15]) ? (sum_x[16] ? 16'sh8000 : 16'sh7fff)
                                             : sum_x[15:0];
    assign side    = r_cy[15] ? -$signed({1'b0, i_cfg.avoidance_offset})
                              : $signed({1'b0, i_cfg.avoidance_offset});
    assign outer_r = {1'b0, i_cfg.safe_distance} + {1'b0, i_cfg.release_margin};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQY: begin
                mul_a = MW'(r_cy);
                mul_b = MW'(r_cy);
            end
            OP_SQZ: begin
                mul_a = MW'(r_cz);
                mul_b = MW'(r_cz);
            end
            OP_SQIN: begin
                mul_a = $signed({2'b00, i_cfg.safe_distance});
                mul_b = $signed({2'b00, i_cfg.safe_distance});
            end
            OP_SQOUT: begin
                mul_a = $signed({1'b0, outer_r});
                mul_b = $signed({1'b0, outer_r});
            end
            OP_SQGX: begin
                mul_a = MW'(r_gx);
                mul_b = MW'(r_gx);
            end
            OP_SQGY: begin
                mul_a = MW'(r_gy);
                mul_b = MW'(r_gy);
            end
            OP_SPEED: begin
                mul_a = $signed({7'd0, i_cfg.linear_gain});
                mul_b = $signed({1'b0, r_root[15:0]});
            end
            OP_RATE: begin
                mul_a = $signed({7'd0, i_cfg.angular_gain});
                mul_b = MW'(r_ang);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Square root and CORDIC step logic.
    assign trial  = {1'b0, r_root} + {1'b0, r_bit};
    assign xs     = r_x >>> r_cnt;
    assign ys     = r_y >>> r_cnt;
    assign atan_s = $signed(ZW'(atan_q16(r_cnt)));
    assign z_rnd  = r_z + ZW'(8);
    assign gx_ext = CW'(r_gx);
    assign gy_ext = CW'(r_gy);

    assign speed_raw  = r_prod[25:8];
    assign rate_raw   = r_prod[33:8];
    assign lim        = $signed({11'd0, i_cfg.max_angular_rate});
    assign rate_clamp = (rate_raw > lim) ? lim : ((rate_raw < -lim) ? -lim : rate_raw);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_LOAD: begin
                r_gx   <= gx_sat;
                r_cy   <= signed'(i_s_tdata[31:16]);
                r_cz   <= signed'(i_s_tdata[47:32]);
                r_last <= i_s_tlast;
            end
            OP_SQZ: begin
                r_d2 <= r_prod[31:0];
            end
            OP_SQIN: begin
                r_d2 <= r_d2 + r_prod[31:0];
            end
            OP_SQOUT: begin
                r_lt <= r_d2 < r_prod[31:0];
            end
            OP_GOALY: begin
                if (r_lt) begin
                    r_gy <= side;
                end else if (r_d2 > r_prod[31:0]) begin
                    r_gy <= -side;
                end else begin
                    r_gy <= '0;
                end
            end
            OP_SQGY: begin
                r_rad <= r_prod[31:0];
            end
            OP_INIT: begin
                r_rem  <= r_rad + r_prod[31:0];
                r_root <= '0;
                r_bit  <= 32'h4000_0000;
                r_cnt  <= '0;
                r_zero <= (r_gx == 16'sd0) && (r_gy == 16'sd0);
                if (r_gx[15]) begin
                    if (!r_gy[15]) begin
                        r_x <= gy_ext;
                        r_y <= -gx_ext;
                        r_z <= QUARTER_TURN;
                    end else begin
                        r_x <= -gy_ext;
                        r_y <= gx_ext;
                        r_z <= -QUARTER_TURN;
                    end
                end else begin
                    r_x <= gx_ext;
                    r_y <= gy_ext;
                    r_z <= '0;
                end
            end
            OP_ITER: begin
                r_cnt <= r_cnt + IDX_W'(1);
                if (r_bit != '0) begin
                    if ({1'b0, r_rem} >= trial) begin
                        r_rem  <= r_rem - trial[31:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                if (!r_zero && (r_cnt < IDX_W'(CORDIC_STEPS))) begin
                    if (!r_y[CW-1]) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_s;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_s;
                    end
                end
            end
            OP_SPEED: begin
                r_ang <= r_zero ? 16'sd0 : z_rnd[19:4];
            end
            OP_RATE: begin
                r_speed <= (speed_raw > {2'b00, i_cfg.max_linear_speed})
                           ? i_cfg.max_linear_speed : speed_raw[15:0];
            end
            OP_CLAMP: begin
                r_rate <= -rate_clamp[15:0];
            end
            OP_OUT: begin
                r_o_goal_x <= r_gx;
                r_o_goal_y <= r_gy;
                r_o_valid  <= i_cmd.first;
                r_o_speed  <= i_cmd.first ? r_speed : 16'd0;
                r_o_rate   <= i_cmd.first ? r_rate : 16'sd0;
                r_o_last   <= r_last;
            end
            default: begin
            end
        endcase
    end

    assign o_status.iter_done = (r_cnt == IDX_W'(ITER_STEPS - 1));
    assign o_status.last      = r_last;

    assign o_m_tdata = {r_o_rate, r_o_speed, r_o_goal_y, r_o_goal_x};
    assign o_m_tuser = r_o_valid;
    assign o_m_tlast = r_o_last;

endmodule
